FILE: src/sbda_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the signed binary to decimal ASCII converter.
// No dependencies; every other file imports this package.
package sbda_pkg;

  localparam int VALUE_WIDTH        = 64;
  localparam int VALUE_BITS_DEFAULT = 64;
  localparam int CHAR_WIDTH         = 6;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 6'd57;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

  // Double dabble correction: a BCD digit of five or more gets three added before the shift
  localparam logic [3:0] BCD_LIMIT  = 4'd5;
  localparam logic [3:0] BCD_ADJUST = 4'd3;

  typedef enum logic [1:0] {
    D_IDLE,
    D_SHIFT,
    D_DONE
  } dabble_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SKIP,
    E_SIGN,
    E_DIGIT
  } emit_state_t;

  typedef struct packed {
    logic valid;
    logic negative;
  } handoff_t;

endpackage

FILE: src/sbda_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the converter's input and output.
// Depends on sbda_pkg for field widths.
interface sbda_in_if;
  import sbda_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if;
  import sbda_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] text_char;
  logic                  last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

FILE: src/signed_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Signed binary to decimal ASCII converter, top level. Uses sbda_pkg, sbda_if,
// sbda_dabble and sbda_emit. Conversion runs in the bit-serial double dabble loop; a new
// transaction is accepted only when the loop is idle and its last result was taken.
// The first character appears once the leading zero BCD digits have been skipped; then
// one character per cycle while dout is ready. Emission overlaps the next conversion.
// Synchronous active-high rst empties both stages and the output.
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  sbda_in_if.sink    din,
  sbda_out_if.source dout
);
  import sbda_pkg::*;

  // enough BCD digits for 2**(VALUE_BITS-1)
  localparam int NUM_DIGITS = VALUE_BITS * 3 / 10 + 1;

  logic [VALUE_BITS-1:0]   v;
  logic [VALUE_BITS-1:0]   magnitude;
  logic                    negative;
  logic                    load;
  logic                    idle;
  logic                    take;
  handoff_t                hand;
  logic [NUM_DIGITS*4-1:0] bcd;

  // unsigned magnitude, so the most negative value stays exact
  assign v         = din.value[VALUE_BITS-1:0];
  assign negative  = v[VALUE_BITS-1];
  assign magnitude = negative ? (~v + 1'b1) : v;

  assign din.ready = idle;
  assign load      = din.valid && idle;

  sbda_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .magnitude (magnitude),
    .negative  (negative),
    .take      (take),
    .idle      (idle),
    .hand      (hand),
    .bcd       (bcd)
  );

  sbda_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk  (clk),
    .rst  (rst),
    .hand (hand),
    .bcd  (bcd),
    .take (take),
    .dout (dout)
  );

endmodule

FILE: src/sbda_dabble.sv
`timescale 1ns / 1ps
// Bit-serial double dabble: shifts the magnitude in MSB first, one bit per cycle.
// Depends on sbda_pkg.
module sbda_dabble #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEFAULT,
  parameter int NUM_DIGITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic [VALUE_BITS-1:0]   magnitude,
  input  logic                    negative,
  input  logic                    take,
  output logic                    idle,
  output sbda_pkg::handoff_t      hand,
  output logic [NUM_DIGITS*4-1:0] bcd
);
  import sbda_pkg::*;

  localparam int CW = $clog2(VALUE_BITS);
  localparam int BW = NUM_DIGITS * 4;

  dabble_state_t         state, state_next;
  logic [VALUE_BITS-1:0] mag;
  logic [BW-1:0]         bcd_reg;
  logic [BW-1:0]         adj;
  logic                  neg;
  logic [CW-1:0]         cnt;

  always_comb begin
    logic [3:0] d;
    d   = '0;
    adj = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd_reg[4*i +: 4];
      adj[4*i +: 4] = (d >= BCD_LIMIT) ? d + BCD_ADJUST : d;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE:  if (load) state_next = D_SHIFT;
      D_SHIFT: if (cnt == '0) state_next = D_DONE;
      D_DONE:  if (take) state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag     <= magnitude;
      bcd_reg <= '0;
      neg     <= negative;
      cnt     <= CW'(VALUE_BITS - 1);
    end else if (state == D_SHIFT) begin
      mag     <= {mag[VALUE_BITS-2:0], 1'b0};
      bcd_reg <= {adj[BW-2:0], mag[VALUE_BITS-1]};
      cnt     <= cnt - 1'b1;
    end
  end

  assign idle          = (state == D_IDLE);
  assign hand.valid    = (state == D_DONE);
  assign hand.negative = neg;
  assign bcd           = bcd_reg;

endmodule

FILE: src/sbda_emit.sv
`timescale 1ns / 1ps
// Character emitter: drops leading zero digits, sends any minus sign, then one digit per
// transaction from a 4-bit-per-cycle shift register. Depends on sbda_pkg, sbda_if.
module sbda_emit #(
  parameter int NUM_DIGITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  sbda_pkg::handoff_t      hand,
  input  logic [NUM_DIGITS*4-1:0] bcd,
  output logic                    take,
  sbda_out_if.source              dout
);
  import sbda_pkg::*;

  localparam int CW = $clog2(NUM_DIGITS + 1);
  localparam int BW = NUM_DIGITS * 4;

  emit_state_t           state, state_next;
  logic [BW-1:0]         shreg;
  logic [CW-1:0]         left;
  logic                  neg;
  logic                  o_valid;
  logic [CHAR_WIDTH-1:0] o_char;
  logic                  o_last;
  logic [3:0]            top_digit;
  logic                  slot_free;
  logic                  emit_sign;
  logic                  emit_digit;
  logic                  shift;

  assign top_digit = shreg[BW-1 -: 4];
  assign slot_free = !o_valid || dout.ready;
  assign take      = hand.valid && (state == E_IDLE);

  always_comb begin
    state_next = state;
    emit_sign  = 1'b0;
    emit_digit = 1'b0;
    shift      = 1'b0;
    case (state)
      E_IDLE: begin
        if (take) state_next = E_SKIP;
      end
      E_SKIP: begin
        // drop leading zeros, but always keep the final digit
        if (top_digit == 4'd0 && left != CW'(1)) begin
          shift = 1'b1;
        end else begin
          state_next = neg ? E_SIGN : E_DIGIT;
        end
      end
      E_SIGN: begin
        if (slot_free) begin
          emit_sign  = 1'b1;
          state_next = E_DIGIT;
        end
      end
      E_DIGIT: begin
        if (slot_free) begin
          emit_digit = 1'b1;
          shift      = 1'b1;
          if (left == CW'(1)) state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= E_IDLE;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_sign || emit_digit) begin
        o_valid <= 1'b1;
      end else if (dout.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      shreg <= bcd;
      left  <= CW'(NUM_DIGITS);
      neg   <= hand.negative;
    end else if (shift) begin
      shreg <= {shreg[BW-5:0], 4'd0};
      left  <= left - 1'b1;
    end
    if (emit_sign) begin
      o_char <= CHAR_MINUS;
      o_last <= 1'b0;
    end else if (emit_digit) begin
      o_char <= CHAR_ZERO + {2'b00, top_digit};
      o_last <= (left == CW'(1));
    end
  end

  assign dout.valid     = o_valid;
  assign dout.text_char = o_char;
  assign dout.last_char = o_last;

endmodule

FILE: src/sbda_checker.sv
`timescale 1ns / 1ps
// Output-side checks for the converter, bound to the top level.
// Depends on sbda_pkg and the top level's dout channel.
module sbda_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sbda_pkg::CHAR_WIDTH-1:0] text_char,
  input logic                            last_char
);
  import sbda_pkg::*;

  logic first;
  logic after_minus;

  // track where each number's text starts
  always_ff @(posedge clk) begin
    if (rst) begin
      first       <= 1'b1;
      after_minus <= 1'b0;
    end else if (out_valid && out_ready) begin
      first       <= last_char;
      after_minus <= (text_char == CHAR_MINUS);
    end
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (text_char == CHAR_MINUS ||
                   (text_char >= CHAR_ZERO && text_char <= CHAR_NINE)))
    else $error("character out of range");

  a_minus_leads: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_char == CHAR_MINUS |-> first && !last_char)
    else $error("minus sign not at start of text or ends it");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (first || after_minus) && text_char == CHAR_ZERO |-> last_char && !after_minus)
    else $error("leading zero emitted");

  a_after_minus: assert property (@(posedge clk) disable iff (rst)
    out_valid && after_minus |-> text_char != CHAR_MINUS)
    else $error("repeated minus sign");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last_char))
    else $error("stalled output changed");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .text_char (dout.text_char),
  .last_char (dout.last_char)
);
